// ===== hw/rtl/frame_deframe_crc_check_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the frame deframer
// Concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef FRAME_DEFRAME_CRC_CHECK_ASSERT_SVH
`define FRAME_DEFRAME_CRC_CHECK_ASSERT_SVH

`ifndef ASSERT_OFF
`define FDCC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define FDCC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define FDCC_ASSERT(lbl, prop, msg)
`define FDCC_NEVER(lbl, cond, msg)
`endif

`endif

// ===== hw/rtl/fdcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame deframer package
// Types, constants and the CRC-16 byte update shared by the deframer files.
// ----------------------------------------------------------------------------
package fdcc_pkg;

	localparam int DEF_MAX_PAYLOAD = 255;
	localparam int HDR_BYTES       = 14;
	localparam int CRC_BYTES       = 2;
	localparam int FIFO_DEPTH      = 4;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_ARG = 2'd1,
		ST_CRC_ERR = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CFG_VERSION = 2'd0,
		CFG_TYPES_A = 2'd1,
		CFG_TYPES_B = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_SUMMARY = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		status_t     status;
		logic [7:0]  version;
		logic [7:0]  pkt_type;
		logic [31:0] msg_id;
		logic [31:0] timestamp;
		logic [31:0] node_id;
		logic [7:0]  pay_len;
		logic        run_last;
	} result_t;

	typedef struct packed {
		logic room2;     // at least two free slots
		logic nonempty;
	} fifo_stat_t;

	// reflected CRC-16, one byte, LSB first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic type_listed(input logic [7:0] t, input logic [31:0] a,
			input logic [31:0] b);
		logic hit;
		hit = 1'b0;
		for (int j = 0; j < 4; j++) begin
			if (a[8*j +: 8] == t || b[8*j +: 8] == t) hit = 1'b1;
		end
		return hit;
	endfunction

endpackage

// ===== hw/rtl/frame_deframe_crc_check.sv =====
// ----------------------------------------------------------------------------
// Frame deframer with CRC-16 check
// Header capture, payload forwarding and CRC-16 (0xA001 reflected) frame check.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle when s_axis_tready is high and emits result
// beats on the master side: a payload beat (tuser 0) two bytes behind the input
// and, on the last byte, a summary beat (tuser 1) with status and header. The
// CRC-16 update of a byte is unrolled into combinational logic, so every byte
// is handled in the cycle it is accepted and the results land in a four-entry
// queue. A byte causes zero, one or two beats; the input is ready while the
// queue has two free slots, so frames stream at one byte per cycle as long as
// the sink takes a beat per cycle, and a frame-end byte that also releases a
// payload byte pushes two beats. Configuration writes are taken at once.
// ----------------------------------------------------------------------------
module frame_deframe_crc_check
	import fdcc_pkg::*;
#(
	parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
	input  logic         s_axis_tlast,   // last_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [7:0] payload_byte, [9:8] status, [17:10] version, [25:18] pkt_type,
	// [57:26] msg_id, [89:58] timestamp, [121:90] node_id,
	// [129:122] pay_len, [135:130] zero
	output logic [135:0] m_axis_tdata,
	output logic         m_axis_tuser,   // kind
	output logic         m_axis_tlast,   // run_last
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
`include "frame_deframe_crc_check_assert.svh"

	localparam int FRAME_MIN = HDR_BYTES + CRC_BYTES;
	localparam int CNT_W     = $clog2(MAX_PAYLOAD + FRAME_MIN + 2);
	localparam int PLEN_LIM  = (MAX_PAYLOAD < 255) ? MAX_PAYLOAD : 255;

	localparam logic [CNT_W-1:0] CNT_CAP  = CNT_W'(MAX_PAYLOAD + FRAME_MIN + 1);
	localparam logic [CNT_W-1:0] CNT_MIN  = CNT_W'(FRAME_MIN);
	localparam logic [CNT_W-1:0] CNT_PEND = CNT_W'(MAX_PAYLOAD + FRAME_MIN);
	localparam logic [CNT_W-1:0] CNT_MAXP = CNT_W'(MAX_PAYLOAD);

	// configuration
	logic [7:0]  ver_cfg_q;
	logic [31:0] types_a_q, types_b_q;

	// frame state
	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      crc_q;
	logic [7:0]       dly0_q, dly1_q;
	logic [7:0]       hver_q, htype_q;
	logic [31:0]      hmsg_q, htime_q, hnode_q;

	logic [CNT_W-1:0] cnt_nxt, plen_full;
	logic [15:0]      crc_nxt;
	logic [7:0]       hver_nxt, htype_nxt, plen_sat;
	logic [31:0]      hmsg_nxt, htime_nxt, hnode_nxt;
	logic             s_fire, emit_pay, is_short, overlong;
	status_t          status;
	result_t          pay_res, sum_res, out_res;
	logic [1:0]       push_cnt;
	fifo_stat_t       fstat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ver_cfg_q <= 8'd1;
			types_a_q <= '0;
			types_b_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_VERSION: ver_cfg_q <= cfg_data[7:0];
				CFG_TYPES_A: types_a_q <= cfg_data;
				CFG_TYPES_B: types_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_axis_tready = fstat.room2;
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	// fold the byte leaving the delay line into the CRC
	assign crc_nxt  = (cnt_q >= CNT_W'(CRC_BYTES)) ? crc16_byte(crc_q, dly1_q) : crc_q;
	assign emit_pay = (cnt_q >= CNT_MIN) && (cnt_q < CNT_PEND);
	assign cnt_nxt  = (cnt_q == CNT_CAP) ? cnt_q : cnt_q + CNT_W'(1);

	always_comb begin
		hver_nxt  = hver_q;
		htype_nxt = htype_q;
		hmsg_nxt  = hmsg_q;
		htime_nxt = htime_q;
		hnode_nxt = hnode_q;
		priority if (cnt_q == CNT_W'(0)) hver_nxt = s_axis_tdata;
		else if (cnt_q == CNT_W'(1)) htype_nxt = s_axis_tdata;
		else if (cnt_q < CNT_W'(6)) hmsg_nxt = {hmsg_q[23:0], s_axis_tdata};
		else if (cnt_q < CNT_W'(10)) htime_nxt = {htime_q[23:0], s_axis_tdata};
		else if (cnt_q < CNT_W'(HDR_BYTES)) hnode_nxt = {hnode_q[23:0], s_axis_tdata};
	end

	// summary checks, on the count after this byte
	assign is_short  = cnt_nxt < CNT_MIN;
	assign plen_full = cnt_nxt - CNT_MIN;
	assign overlong  = !is_short && (plen_full > CNT_MAXP);

	always_comb begin
		priority if (is_short) status = ST_BAD_ARG;
		else if (hver_nxt != ver_cfg_q) status = ST_BAD_ARG;
		else if (!type_listed(htype_nxt, types_a_q, types_b_q)) status = ST_BAD_ARG;
		else if (overlong) status = ST_BAD_ARG;
		else if ({dly0_q, s_axis_tdata} == crc_nxt) status = ST_OK;
		else status = ST_CRC_ERR;
	end

	always_comb begin
		priority if (is_short) plen_sat = 8'd0;
		else if (plen_full > CNT_W'(PLEN_LIM)) plen_sat = 8'(PLEN_LIM);
		else plen_sat = plen_full[7:0];
	end

	always_comb begin
		pay_res              = '0;
		pay_res.kind         = KIND_PAYLOAD;
		pay_res.payload_byte = dly1_q;
		pay_res.status       = ST_OK;
		pay_res.run_last     = !s_axis_tlast;

		sum_res            = '0;
		sum_res.kind       = KIND_SUMMARY;
		sum_res.status     = status;
		sum_res.version    = hver_nxt;
		sum_res.pkt_type   = htype_nxt;
		sum_res.msg_id     = hmsg_nxt;
		sum_res.timestamp  = htime_nxt;
		sum_res.node_id    = hnode_nxt;
		sum_res.pay_len    = plen_sat;
		sum_res.run_last   = 1'b1;
	end

	assign push_cnt = s_fire ? (2'(emit_pay) + 2'(s_axis_tlast)) : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			crc_q   <= CRC_INIT;
			dly0_q  <= '0;
			dly1_q  <= '0;
			hver_q  <= '0;
			htype_q <= '0;
			hmsg_q  <= '0;
			htime_q <= '0;
			hnode_q <= '0;
		end else if (s_fire) begin
			if (s_axis_tlast) begin
				// frame done: back to a clean start
				cnt_q   <= '0;
				crc_q   <= CRC_INIT;
				dly0_q  <= '0;
				dly1_q  <= '0;
				hver_q  <= '0;
				htype_q <= '0;
				hmsg_q  <= '0;
				htime_q <= '0;
				hnode_q <= '0;
			end else begin
				cnt_q   <= cnt_nxt;
				crc_q   <= crc_nxt;
				dly0_q  <= s_axis_tdata;
				dly1_q  <= dly0_q;
				hver_q  <= hver_nxt;
				htype_q <= htype_nxt;
				hmsg_q  <= hmsg_nxt;
				htime_q <= htime_nxt;
				hnode_q <= hnode_nxt;
			end
		end
	end

	fdcc_result_fifo #(
		.DEPTH (FIFO_DEPTH),
		.WIDTH ($bits(result_t))
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cnt   (push_cnt),
		.push_data0 (emit_pay ? pay_res : sum_res),
		.push_data1 (sum_res),
		.pop        (m_axis_tready),
		.pop_data   (out_res),
		.stat       (fstat)
	);

	assign m_axis_tvalid = fstat.nonempty;
	assign m_axis_tuser  = out_res.kind;
	assign m_axis_tlast  = out_res.run_last;
	assign m_axis_tdata  = {6'd0, out_res.pay_len, out_res.node_id, out_res.timestamp,
		out_res.msg_id, out_res.pkt_type, out_res.version, out_res.status,
		out_res.payload_byte};

	`FDCC_ASSERT(a_frame_restart, s_fire && s_axis_tlast |=> (cnt_q == '0) && (crc_q == CRC_INIT),
		"frame state not cleared after last beat")
	`FDCC_ASSERT(a_count_moves, s_fire && !s_axis_tlast |=> cnt_q != '0,
		"byte count did not advance")
	`FDCC_NEVER(a_payload_clean, m_axis_tvalid && (out_res.kind == KIND_PAYLOAD)
		&& (out_res.status != ST_OK), "payload beat carries a status")

endmodule

// ===== hw/rtl/fdcc_result_fifo.sv =====
// ----------------------------------------------------------------------------
// Result queue
// Small register queue that takes up to two results per cycle and hands out one.
// ----------------------------------------------------------------------------
module fdcc_result_fifo
	import fdcc_pkg::*;
#(
	parameter int DEPTH = FIFO_DEPTH,
	parameter int WIDTH = $bits(result_t)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_cnt,
	input  logic [WIDTH-1:0] push_data0,
	input  logic [WIDTH-1:0] push_data1,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output fifo_stat_t       stat
);
`include "frame_deframe_crc_check_assert.svh"

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [IDX_W-1:0] wr_q, rd_q, wr_plus1;
	logic [CNT_W-1:0] cnt_q;
	logic             do_pop;

	assign wr_plus1 = wr_q + IDX_W'(1);
	assign do_pop   = pop && (cnt_q != '0);

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) mem_q[wr_q] <= push_data0;
		if (push_cnt == 2'd2) mem_q[wr_plus1] <= push_data1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + IDX_W'(push_cnt);
			if (do_pop) rd_q <= rd_q + IDX_W'(1);
			cnt_q <= cnt_q + CNT_W'(push_cnt) - CNT_W'(do_pop);
		end
	end

	assign pop_data       = mem_q[rd_q];
	assign stat.nonempty  = (cnt_q != '0);
	assign stat.room2     = (cnt_q <= CNT_W'(DEPTH - 2));

	`FDCC_NEVER(a_fifo_overfill, cnt_q > CNT_W'(DEPTH), "result queue over capacity")
	`FDCC_NEVER(a_fifo_push_full, (push_cnt == 2'd2) && (cnt_q > CNT_W'(DEPTH - 2)),
		"two results pushed without room")

endmodule
